>>> hdl/etbd_pkg.sv
// shared constants and field layout for the button debouncer
`default_nettype none

package etbd_pkg;

    localparam int unsigned NUM_BUTTONS_DEF = 8;
    localparam int unsigned MASK_W          = 8;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned DT_W            = 16;
    localparam int unsigned SEL_W           = 3;
    localparam int unsigned COUNT_W         = 32;

    localparam logic [DT_W-1:0] DEBOUNCE_RESET = 16'd20;

    // input word layout, lowest bit up
    localparam int unsigned IN_NOW_LO    = 0;
    localparam int unsigned IN_EDGE_LO   = IN_NOW_LO + TIME_W;
    localparam int unsigned IN_DEDGE_BIT = IN_EDGE_LO + MASK_W;
    localparam int unsigned IN_LVL_LO    = IN_DEDGE_BIT + 1;
    localparam int unsigned IN_DLVL_BIT  = IN_LVL_LO + MASK_W;
    localparam int unsigned IN_TAKE_LO   = IN_DLVL_BIT + 1;
    localparam int unsigned IN_DTAKE_BIT = IN_TAKE_LO + MASK_W;
    localparam int unsigned IN_SEL_LO    = IN_DTAKE_BIT + 1;
    localparam int unsigned IN_USED      = IN_SEL_LO + SEL_W;
    localparam int unsigned IN_W         = ((IN_USED + 7) / 8) * 8;

    // output word layout, lowest bit up
    localparam int unsigned OUT_FLAGS_LO   = 0;
    localparam int unsigned OUT_TAKEN_LO   = OUT_FLAGS_LO + MASK_W;
    localparam int unsigned OUT_DTAKEN_BIT = OUT_TAKEN_LO + MASK_W;
    localparam int unsigned OUT_DFLAG_BIT  = OUT_DTAKEN_BIT + 1;
    localparam int unsigned OUT_COUNT_LO   = OUT_DFLAG_BIT + 1;
    localparam int unsigned OUT_USED       = OUT_COUNT_LO + COUNT_W;
    localparam int unsigned OUT_W          = ((OUT_USED + 7) / 8) * 8;

endpackage

`default_nettype wire

>>> hdl/edge_triggered_button_debouncer_unit.sv
// edge-triggered delayed-sample debouncer for up to eight buttons and a display key
`default_nettype none

// One input word per clock, sustained while downstream takes every result. Each word is
// captured in an input register; once the output register is free, every button line and
// the display key run one wrapping 32-bit subtract and compare against the debounce time
// in parallel, the state is updated and the result word is loaded into the output
// register. Both stages stall only while the output register holds a word that
// downstream has not taken. debounce_time is written through the cfg channel, which is
// always ready; the user must write it only while no word is in flight, and the block
// itself does not enforce this. Button lines at or above NUM_BUTTONS keep no state.
module edge_triggered_button_debouncer_unit #(
    parameter int unsigned NUM_BUTTONS = etbd_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [etbd_pkg::DT_W-1:0]     i_cfg_data,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // now_ms, edge_mask, display_edge, button_levels, display_level,
    // take_mask, take_display, count_select, zero fill
    input  wire logic [etbd_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // press_flags, taken_mask, display_taken, display_flag, selected_count, zero fill
    output logic [etbd_pkg::OUT_W-1:0]         o_m_axis_tdata
);
    import etbd_pkg::*;

    localparam int unsigned LINES = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;

    // configuration
    logic [DT_W-1:0] r_dt;

    // input stage
    logic              r_in_valid;
    logic [TIME_W-1:0] r_now;
    logic [MASK_W-1:0] r_edge;
    logic              r_dedge;
    logic [MASK_W-1:0] r_lvl;
    logic              r_dlvl;
    logic [MASK_W-1:0] r_take;
    logic              r_dtake;
    logic [SEL_W-1:0]  r_sel;

    // debouncer state
    logic [LINES-1:0]   r_armed, n_armed;
    logic [TIME_W-1:0]  r_start [LINES], n_start [LINES];
    logic [COUNT_W-1:0] r_count [LINES], n_count [LINES];
    logic [LINES-1:0]   r_flags, n_flags;
    logic               r_darmed, n_darmed;
    logic [TIME_W-1:0]  r_dstart, n_dstart;
    logic               r_dpress, n_dpress;

    // result stage
    logic               r_out_valid;
    logic [LINES-1:0]   r_o_flags;
    logic [LINES-1:0]   r_o_taken;
    logic               r_o_dtaken;
    logic               r_o_dflag;
    logic [COUNT_W-1:0] r_o_count;

    logic               adv;
    logic               fire;
    logic [LINES-1:0]   n_taken;
    logic               n_dtaken;
    logic [COUNT_W-1:0] n_sel_count;
    logic               arm;
    logic               close;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  dt_ext;

    assign adv             = !r_out_valid || i_m_axis_tready;
    assign fire            = adv && r_in_valid;
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready     = 1'b1;
    assign dt_ext          = TIME_W'(r_dt);

    always_comb begin
        n_armed     = r_armed;
        n_start     = r_start;
        n_count     = r_count;
        n_flags     = r_flags;
        n_darmed    = r_darmed;
        n_dstart    = r_dstart;
        n_dpress    = r_dpress;
        n_taken     = '0;
        n_dtaken    = 1'b0;
        n_sel_count = '0;
        arm         = 1'b0;
        close       = 1'b0;
        start       = '0;

        // arm on edge, then close once the window has run its length
        for (int i = 0; i < LINES; i++) begin
            arm        = r_edge[i] | r_armed[i];
            start      = r_edge[i] ? r_now : r_start[i];
            close      = arm && ((r_now - start) >= dt_ext);
            n_armed[i] = arm && !close;
            n_start[i] = start;
            if (close && r_lvl[i]) begin
                n_flags[i] = 1'b1;
                n_count[i] = r_count[i] + COUNT_W'(1);
            end
        end

        arm      = r_dedge | r_darmed;
        start    = r_dedge ? r_now : r_dstart;
        close    = arm && ((r_now - start) >= dt_ext);
        n_darmed = arm && !close;
        n_dstart = start;
        if (close && r_dlvl) begin
            n_dpress = 1'b1;
        end

        // takes act on the flags as they stand after this word's sampling
        for (int i = 0; i < LINES; i++) begin
            if (r_take[i] && n_flags[i]) begin
                n_flags[i] = 1'b0;
                n_taken[i] = 1'b1;
            end
        end
        if (r_dtake && n_dpress) begin
            n_dpress = 1'b0;
            n_dtaken = 1'b1;
        end

        for (int i = 0; i < LINES; i++) begin
            if (32'(r_sel) == i) begin
                n_sel_count = n_count[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            r_dt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_now   <= i_s_axis_tdata[IN_NOW_LO +: TIME_W];
            r_edge  <= i_s_axis_tdata[IN_EDGE_LO +: MASK_W];
            r_dedge <= i_s_axis_tdata[IN_DEDGE_BIT];
            r_lvl   <= i_s_axis_tdata[IN_LVL_LO +: MASK_W];
            r_dlvl  <= i_s_axis_tdata[IN_DLVL_BIT];
            r_take  <= i_s_axis_tdata[IN_TAKE_LO +: MASK_W];
            r_dtake <= i_s_axis_tdata[IN_DTAKE_BIT];
            r_sel   <= i_s_axis_tdata[IN_SEL_LO +: SEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= '0;
            r_flags  <= '0;
            r_darmed <= 1'b0;
            r_dstart <= '0;
            r_dpress <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_start[i] <= '0;
                r_count[i] <= '0;
            end
        end else if (fire) begin
            r_armed  <= n_armed;
            r_flags  <= n_flags;
            r_darmed <= n_darmed;
            r_dstart <= n_dstart;
            r_dpress <= n_dpress;
            r_start  <= n_start;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_o_flags  <= n_flags;
            r_o_taken  <= n_taken;
            r_o_dtaken <= n_dtaken;
            r_o_dflag  <= n_dpress;
            r_o_count  <= n_sel_count;
        end
    end

    always_comb begin
        o_m_axis_tdata                                = '0;
        o_m_axis_tdata[OUT_FLAGS_LO +: MASK_W]        = MASK_W'(r_o_flags);
        o_m_axis_tdata[OUT_TAKEN_LO +: MASK_W]        = MASK_W'(r_o_taken);
        o_m_axis_tdata[OUT_DTAKEN_BIT]                = r_o_dtaken;
        o_m_axis_tdata[OUT_DFLAG_BIT]                 = r_o_dflag;
        o_m_axis_tdata[OUT_COUNT_LO +: COUNT_W]       = r_o_count;
    end

    assign o_m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

>>> bench/tb_edge_triggered_button_debouncer_unit.sv
// self-checking stream testbench for the edge-triggered button debouncer
module tb_edge_triggered_button_debouncer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import etbd_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_PAUSE  = 4;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 125;
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [TIME_W-1:0]  now;
        logic [MASK_W-1:0]  edges;
        logic               disp_edge;
        logic [MASK_W-1:0]  levels;
        logic               disp_level;
        logic [MASK_W-1:0]  takes;
        logic               disp_take;
        logic [SEL_W-1:0]   sel;
    } t_press_item;

    typedef struct packed {
        logic [MASK_W-1:0]  flags;
        logic [MASK_W-1:0]  taken;
        logic               disp_taken;
        logic               disp_flag;
        logic [COUNT_W-1:0] count;
    } t_press_report;

    // a word on its way in, with a hand-written result where one is known
    typedef struct {
        t_press_item   item;
        bit            typed;
        t_press_report want;
    } t_word_note;

    typedef struct {
        bit            set_dt;
        logic [DT_W-1:0] dt_val;
        t_word_note    note;
    } t_drill_row;

    typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_PATTERN, RX_STARVED} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [DT_W-1:0]     i_cfg_data = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    o_m_axis_tdata;

    edge_triggered_button_debouncer_unit #(
        .NUM_BUTTONS(NUM_BUTTONS_DEF)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // debouncer state as the block should hold it
    logic [DT_W-1:0]    model_dt = DEBOUNCE_RESET;
    logic               arm_on [NUM_BUTTONS_DEF] = '{default: 1'b0};
    logic [TIME_W-1:0]  arm_ms [NUM_BUTTONS_DEF] = '{default: '0};
    logic [COUNT_W-1:0] press_tally [NUM_BUTTONS_DEF] = '{default: '0};
    logic [MASK_W-1:0]  pending_flags = '0;
    logic               disp_on = 1'b0;
    logic [TIME_W-1:0]  disp_ms = '0;
    logic               disp_pending = 1'b0;

    t_word_note    in_flight [$];
    t_press_report due_reports [$];
    t_drill_row    drill [$];

    int mismatches = 0;
    int words_sent = 0;
    int reports_checked = 0;
    int press_events = 0;
    int flags_taken = 0;
    int dt_writes = 0;
    int burst_left = 0;
    int quiet_cycles = 0;

    t_rx_mode   rx_mode = RX_OPEN;
    logic [31:0] rx_bits = '0;
    logic [5:0]  rx_tick = '0;

    function automatic t_press_report debounce_step(t_press_item it);
        t_press_report r;
        logic [TIME_W-1:0] held;
        r = '0;
        for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
            if (it.edges[b]) begin
                arm_on[b] = 1'b1;
                arm_ms[b] = it.now;
            end
            held = it.now - arm_ms[b];
            if (arm_on[b] && held >= TIME_W'(model_dt)) begin
                arm_on[b] = 1'b0;
                if (it.levels[b]) begin
                    pending_flags[b] = 1'b1;
                    press_tally[b] = press_tally[b] + 1'b1;
                    press_events++;
                end
            end
        end
        if (it.disp_edge) begin
            disp_on = 1'b1;
            disp_ms = it.now;
        end
        held = it.now - disp_ms;
        if (disp_on && held >= TIME_W'(model_dt)) begin
            disp_on = 1'b0;
            if (it.disp_level) begin
                disp_pending = 1'b1;
                press_events++;
            end
        end
        // takes act only after this word's windows have closed
        for (int b = 0; b < NUM_BUTTONS_DEF; b++) begin
            if (it.takes[b] && pending_flags[b]) begin
                pending_flags[b] = 1'b0;
                r.taken[b] = 1'b1;
                flags_taken++;
            end
        end
        if (it.disp_take && disp_pending) begin
            disp_pending = 1'b0;
            r.disp_taken = 1'b1;
            flags_taken++;
        end
        r.flags = pending_flags;
        r.disp_flag = disp_pending;
        r.count = press_tally[it.sel];
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_button_word(t_press_item it);
        logic [IN_W-1:0] w;
        w = '0;
        w[IN_NOW_LO +: TIME_W] = it.now;
        w[IN_EDGE_LO +: MASK_W] = it.edges;
        w[IN_DEDGE_BIT] = it.disp_edge;
        w[IN_LVL_LO +: MASK_W] = it.levels;
        w[IN_DLVL_BIT] = it.disp_level;
        w[IN_TAKE_LO +: MASK_W] = it.takes;
        w[IN_DTAKE_BIT] = it.disp_take;
        w[IN_SEL_LO +: SEL_W] = it.sel;
        return w;
    endfunction

    function automatic t_press_report unpack_report(logic [OUT_W-1:0] w);
        t_press_report r;
        r.flags = w[OUT_FLAGS_LO +: MASK_W];
        r.taken = w[OUT_TAKEN_LO +: MASK_W];
        r.disp_taken = w[OUT_DTAKEN_BIT];
        r.disp_flag = w[OUT_DFLAG_BIT];
        r.count = w[OUT_COUNT_LO +: COUNT_W];
        return r;
    endfunction

    function automatic void flag_mismatch(string what, t_press_report want,
                                          t_press_report got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
            $display("  want flags=%h taken=%h dtaken=%b dflag=%b count=%h",
                     want.flags, want.taken, want.disp_taken, want.disp_flag, want.count);
            $display("  got  flags=%h taken=%h dtaken=%b dflag=%b count=%h",
                     got.flags, got.taken, got.disp_taken, got.disp_flag, got.count);
        end
    endfunction

    function automatic void add_row(logic [TIME_W-1:0] now, logic [MASK_W-1:0] edges,
                                    logic dedge, logic [MASK_W-1:0] levels, logic dlevel,
                                    logic [MASK_W-1:0] takes, logic dtake,
                                    logic [SEL_W-1:0] sel);
        t_drill_row row;
        row.set_dt = 1'b0;
        row.dt_val = '0;
        row.note.item = '{now, edges, dedge, levels, dlevel, takes, dtake, sel};
        row.note.typed = 1'b0;
        row.note.want = '0;
        drill.push_back(row);
    endfunction

    function automatic void add_dt(logic [DT_W-1:0] v);
        t_drill_row row;
        row.set_dt = 1'b1;
        row.dt_val = v;
        row.note.item = '0;
        row.note.typed = 1'b0;
        row.note.want = '0;
        drill.push_back(row);
    endfunction

    // inputs are taken before results so the order inside a step is fixed
    always @(posedge i_clk) begin : scoreboard
        t_word_note    note;
        t_press_report predicted;
        t_press_report got;
        if (i_cfg_valid && o_cfg_ready) begin
            model_dt = i_cfg_data;
            dt_writes++;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            note = in_flight.pop_front();
            predicted = debounce_step(note.item);
            due_reports.push_back(note.typed ? note.want : predicted);
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got = unpack_report(o_m_axis_tdata);
            if (due_reports.size() == 0) begin
                flag_mismatch("result word with nothing pending", '0, got);
            end else begin
                predicted = due_reports.pop_front();
                reports_checked++;
                if (got !== predicted) begin
                    flag_mismatch("result word differs", predicted, got);
                end
            end
        end
    end

    // receiver back-pressure, a new mode each time rx_tick wraps
    always @(posedge i_clk) begin
        if (rx_tick == '0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_bits <= $urandom;
        end
        rx_tick <= rx_tick + 1'b1;
        case (rx_mode)
            RX_OPEN: begin
                i_m_axis_tready <= 1'b1;
            end
            RX_SPOTTY: begin
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            RX_PATTERN: begin
                i_m_axis_tready <= rx_bits[rx_tick[4:0]];
            end
            default: begin
                i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results still pending",
                     QUIET_LIMIT, due_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(input t_word_note note);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_flight.push_back(note);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= pack_button_word(note.item);
        do @(posedge i_clk); while (!o_s_axis_tready);
        words_sent++;
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_reports.size() != 0 || in_flight.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_debounce(input logic [DT_W-1:0] v);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [DT_W-1:0]   phase_dt [PHASES];
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] last_edge_ms;
        logic [63:0]       noise;
        t_word_note        note;
        int                span;
        int                pick;
        int                directed_words;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // straight after reset nothing is pending
        add_row(32'h0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0);
        drill[drill.size()-1].note.typed = 1'b1;
        // arm every line, then restart button 0 while armed
        add_row(32'd100, 8'hFF, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b0, 3'd0);
        add_row(32'd110, 8'h01, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 3'd0);
        // windows close at exactly the debounce time, button 7 reads low
        add_row(32'd120, 8'h00, 1'b0, 8'h7F, 1'b1, 8'h00, 1'b0, 3'd1);
        add_row(32'd130, 8'h00, 1'b0, 8'h01, 1'b0, 8'hFF, 1'b1, 3'd0);
        // taking flags that are already clear does nothing
        add_row(32'd131, 8'h00, 1'b0, 8'h00, 1'b0, 8'hFF, 1'b1, 3'd7);
        drill[drill.size()-1].note.typed = 1'b1;
        // zero debounce closes in the edge's own word, at the top of time
        add_dt(16'd0);
        add_row(32'hFFFF_FFFF, 8'h04, 1'b1, 8'h04, 1'b0, 8'h00, 1'b0, 3'd2);
        add_row(32'hFFFF_FFFF, 8'h80, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 3'd7);
        add_row(32'h0, 8'h00, 1'b0, 8'hFF, 1'b1, 8'h04, 1'b0, 3'd2);
        // longest debounce, window spans the time wrap
        add_dt(16'hFFFF);
        add_row(32'hFFFF_FFF0, 8'h18, 1'b1, 8'hFF, 1'b1, 8'h00, 1'b0, 3'd3);
        add_row(32'h0000_FFEE, 8'h00, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0, 3'd3);
        add_row(32'h0000_FFEF, 8'h00, 1'b0, 8'h08, 1'b1, 8'h00, 1'b0, 3'd3);
        add_row(32'h0000_FFF0, 8'h00, 1'b0, 8'h00, 1'b0, 8'hFF, 1'b1, 3'd4);
        add_dt(16'd1);
        add_row(32'd5, 8'h60, 1'b0, 8'h60, 1'b0, 8'h00, 1'b0, 3'd5);
        add_row(32'd5, 8'h40, 1'b0, 8'h60, 1'b0, 8'h20, 1'b0, 3'd6);
        add_row(32'd6, 8'h00, 1'b0, 8'h40, 1'b0, 8'h40, 1'b0, 3'd6);

        foreach (drill[k]) begin
            if (drill[k].set_dt) begin
                write_debounce(drill[k].dt_val);
            end else begin
                send_word(drill[k].note);
            end
        end
        directed_words = words_sent;

        phase_dt[0] = 16'd0;
        phase_dt[1] = 16'hFFFF;
        phase_dt[2] = 16'd1;
        phase_dt[3] = 16'($urandom_range(2, 64));
        phase_dt[4] = DEBOUNCE_RESET;
        phase_dt[5] = 16'($urandom);

        clock_ms = $urandom;
        last_edge_ms = clock_ms;
        note.typed = 1'b0;
        note.want = '0;
        for (int p = 0; p < PHASES; p++) begin
            write_debounce(phase_dt[p]);
            span = int'(phase_dt[p]) / 3 + 2;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    // noise: any word at all
                    noise = {$urandom, $urandom};
                    note.item = noise[IN_USED-1:0];
                    clock_ms = note.item.now;
                end else begin
                    // land right on or just short of the window end now and then
                    if (pick == 1) begin
                        clock_ms = last_edge_ms + TIME_W'(phase_dt[p]);
                    end else if (pick == 2) begin
                        clock_ms = last_edge_ms + TIME_W'(phase_dt[p]) - 1'b1;
                    end else begin
                        clock_ms = clock_ms + TIME_W'($urandom_range(0, span));
                    end
                    note.item.now = clock_ms;
                    note.item.edges = 8'($urandom & $urandom);
                    note.item.disp_edge = ($urandom_range(0, 5) == 0);
                    note.item.levels = 8'($urandom | $urandom);
                    note.item.disp_level = ($urandom_range(0, 3) != 0);
                    note.item.takes = 8'($urandom);
                    note.item.disp_take = ($urandom_range(0, 1) == 1);
                    note.item.sel = 3'($urandom_range(0, 7));
                end
                if (note.item.edges != '0 || note.item.disp_edge) begin
                    last_edge_ms = note.item.now;
                end
                send_word(note);
            end
        end

        drain_pipeline();

        $display("sent %0d words (%0d directed) under %0d debounce settings",
                 words_sent, directed_words, dt_writes + 1);
        $display("checked %0d results: %0d presses recorded, %0d flags consumed",
                 reports_checked, press_events, flags_taken);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
